// ----- sv/fifo_tlb_top_assert.svh -----
// ----------------------------------------------------------------------------
// fifo_tlb_top_assert.svh: assertion macros
// Shorthands for clocked concurrent assertions, used in fifo_tlb_top.
// ----------------------------------------------------------------------------
`ifndef FIFO_TLB_TOP_ASSERT_SVH
`define FIFO_TLB_TOP_ASSERT_SVH

// Checked on every rising edge of clk_i while reset is released.
`define FT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define FT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/ftlb_pkg.sv -----
// ----------------------------------------------------------------------------
// ftlb_pkg: shared types and constants
// Sizes, request codes and the word types that travel along the cell chain.
// ----------------------------------------------------------------------------
package ftlb_pkg;

  localparam int TLB_DEPTH  = 16;
  localparam int PAGE_BITS  = 52;
  localparam int FRAME_BITS = 40;

  localparam int IDX_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int ACT_W     = 5;
  localparam int ACT_RESET = (TLB_DEPTH < 16) ? TLB_DEPTH : 16;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_ACTIVE_ENTRIES = 1'b0;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_INVAL  = 2'd2
  } req_e;

  typedef struct packed {
    logic                  valid;
    logic [1:0]            req_type;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    logic                  hit;
    logic [FRAME_BITS-1:0] found;
  } tok_t;

  typedef struct packed {
    logic                  clear;
    logic [ACT_W-1:0]      n;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [PAGE_BITS-1:0]  wr_page;
    logic [FRAME_BITS-1:0] wr_frame;
  } ctrl_t;

endpackage

// ----- sv/ftlb_req_if.sv -----
// ----------------------------------------------------------------------------
// ftlb_req_if: request channel
// Valid/ready channel carrying one translation request word.
// ----------------------------------------------------------------------------
interface ftlb_req_if import ftlb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [PAGE_BITS-1:0]  page_number;
  logic [FRAME_BITS-1:0] new_frame;

  modport source (output valid, req_type, page_number, new_frame, input ready);
  modport sink (input valid, req_type, page_number, new_frame, output ready);
endinterface

// ----- sv/ftlb_resp_if.sv -----
// ----------------------------------------------------------------------------
// ftlb_resp_if: response channel
// Valid/ready channel carrying one translation result word.
// ----------------------------------------------------------------------------
interface ftlb_resp_if import ftlb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [FRAME_BITS-1:0] found_frame;

  modport source (output valid, hit, found_frame, input ready);
  modport sink (input valid, hit, found_frame, output ready);
endinterface

// ----- sv/ftlb_cell.sv -----
// ----------------------------------------------------------------------------
// ftlb_cell: one translation entry
// Holds one page/frame pair, checks the passing request word against it,
// acts on a match and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module ftlb_cell import ftlb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  ctrl_t            ctrl_i,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic                  valid_q, valid_d;
  logic [PAGE_BITS-1:0]  page_q, page_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  tok_t                  tok_q, tok_d;
  logic                  in_use, match, first, wr_me;

  assign in_use = 32'(idx_i) < 32'(ctrl_i.n);
  assign match  = tok_i.valid && in_use && valid_q && (page_q == tok_i.page);
  assign first  = match && !tok_i.hit;
  assign wr_me  = ctrl_i.wr_en && (ctrl_i.wr_idx == idx_i);

  always_comb begin
    tok_d = tok_i;
    if (first) begin
      tok_d.hit = 1'b1;
      if (tok_i.req_type == REQ_LOOKUP) begin
        tok_d.found = frame_q;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    page_d  = page_q;
    frame_d = frame_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (wr_me) begin
      valid_d = 1'b1;
      page_d  = ctrl_i.wr_page;
      frame_d = ctrl_i.wr_frame;
    end else if (match && (tok_i.req_type == REQ_INVAL)) begin
      valid_d = 1'b0;
    end else if (first && (tok_i.req_type == REQ_INSERT)) begin
      frame_d = tok_i.frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    frame_q <= frame_d;
  end

  assign tok_o = tok_q;

endmodule

// ----- sv/fifo_tlb_top.sv -----
// ----------------------------------------------------------------------------
// fifo_tlb_top: fully associative TLB with FIFO replacement
// Request and response channels, APB register port and the cell chain.
// ----------------------------------------------------------------------------
// Each request word walks down a chain of TLB_DEPTH entry cells, one cell per
// cycle, and one request is handled at a time: a new request is taken only
// when the chain is empty and the result register is free. From the last cell
// the result goes to the result register and then to the output register,
// which drives the response and holds it until it is accepted. A response
// may wait in the output register while the next request is already in the
// chain. Register active_entries (byte address 0) sets the number of entries
// in use, saturates at TLB_DEPTH, and every write to it empties the table.
module fifo_tlb_top import ftlb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ftlb_req_if.sink          req,
  ftlb_resp_if.source       resp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

`include "fifo_tlb_top_assert.svh"

  tok_t                  tok [TLB_DEPTH+1];
  ctrl_t                 ctrl;
  logic [TLB_DEPTH-1:0]  tok_vld;
  logic [ACT_W-1:0]      act_q, act_d;
  logic [IDX_W-1:0]      ptr_q, ptr_d;
  logic                  busy_q, busy_d;
  logic                  done_vld_q, done_vld_d;
  logic                  done_hit_q;
  logic [FRAME_BITS-1:0] done_found_q;
  logic                  out_vld_q, out_vld_d;
  logic                  out_hit_q;
  logic [FRAME_BITS-1:0] out_found_q;
  logic                  accept, cfg_wr, tail, ins_miss, move;
  logic [31:0]           p_eff, p_nxt;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE_ENTRIES) ? APB_DW'(act_q) : '0;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_ENTRIES);

  always_comb begin
    if (32'(pwdata[ACT_W-1:0]) > TLB_DEPTH) begin
      act_d = ACT_W'(TLB_DEPTH);
    end else begin
      act_d = pwdata[ACT_W-1:0];
    end
  end

  assign req.ready = !busy_q && !done_vld_q;
  assign accept    = req.valid && req.ready;

  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = accept;
    tok[0].req_type = req.req_type;
    tok[0].page     = req.page_number;
    tok[0].frame    = req.new_frame;
  end

  assign tail     = tok[TLB_DEPTH].valid;
  assign ins_miss = tail && (tok[TLB_DEPTH].req_type == REQ_INSERT) &&
                    !tok[TLB_DEPTH].hit && (act_q != '0);

  always_comb begin
    p_eff = (32'(ptr_q) >= 32'(act_q)) ? 32'd0 : 32'(ptr_q);
    p_nxt = (p_eff + 32'd1 >= 32'(act_q)) ? 32'd0 : p_eff + 32'd1;
  end

  always_comb begin
    ctrl.clear    = cfg_wr;
    ctrl.n        = act_q;
    ctrl.wr_en    = ins_miss;
    ctrl.wr_idx   = IDX_W'(p_eff);
    ctrl.wr_page  = tok[TLB_DEPTH].page;
    ctrl.wr_frame = tok[TLB_DEPTH].frame;
  end

  for (genvar i = 0; i < TLB_DEPTH; i++) begin : g_cell
    ftlb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(i)),
      .ctrl_i (ctrl),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
    assign tok_vld[i] = tok[i+1].valid;
  end

  assign move = done_vld_q && (!out_vld_q || resp.ready);

  always_comb begin
    busy_d     = busy_q;
    done_vld_d = done_vld_q;
    out_vld_d  = out_vld_q;
    ptr_d      = ptr_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (tail) begin
      busy_d = 1'b0;
    end
    if (tail) begin
      done_vld_d = 1'b1;
    end else if (move) begin
      done_vld_d = 1'b0;
    end
    if (move) begin
      out_vld_d = 1'b1;
    end else if (resp.ready) begin
      out_vld_d = 1'b0;
    end
    if (cfg_wr) begin
      ptr_d = '0;
    end else if (ins_miss) begin
      ptr_d = IDX_W'(p_nxt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= ACT_W'(ACT_RESET);
      ptr_q      <= '0;
      busy_q     <= 1'b0;
      done_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        act_q <= act_d;
      end
      ptr_q      <= ptr_d;
      busy_q     <= busy_d;
      done_vld_q <= done_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail) begin
      done_hit_q   <= tok[TLB_DEPTH].hit;
      done_found_q <= tok[TLB_DEPTH].found;
    end
    if (move) begin
      out_hit_q   <= done_hit_q;
      out_found_q <= done_found_q;
    end
  end

  assign resp.valid       = out_vld_q;
  assign resp.hit         = out_hit_q;
  assign resp.found_frame = out_found_q;

  `FT_ASSERT_ALWAYS(a_one_word_in_chain, $onehot0(tok_vld), "more than one word in the chain")
  `FT_ASSERT(a_done_free_at_tail, tail |-> !done_vld_q, "result overwritten at chain exit")
  `FT_ASSERT(a_ptr_cleared, cfg_wr |=> (ptr_q == '0), "pointer not cleared by config write")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the FIFO-replacement translation buffer
// A directed table walks empty, full and disabled tables, updates in place,
// invalidates, no-op requests and oldest-entry eviction. Random phases then
// mix operations over a small pool of pages under several entry counts,
// with bursty requests and a stalling response side, checking each response
// word against an in-bench model of the table.
// ----------------------------------------------------------------------------
module testbench;
  import ftlb_pkg::*;

  localparam logic [1:0]            REQ_NOP      = 2'd3;
  localparam logic [APB_AW-1:0]     ENTRIES_ADDR = APB_AW'(4 * REG_ACTIVE_ENTRIES);
  localparam logic [PAGE_BITS-1:0]  PAGE_ALL     = '1;
  localparam logic [FRAME_BITS-1:0] FRAME_ALL    = '1;
  localparam int                    POOL_MAX     = 24;

  typedef struct packed {
    logic [1:0]            kind;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
  } tlb_req_t;

  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame;
  } tlb_result_t;

  typedef struct packed {
    bit                    cfg;
    logic [ACT_W-1:0]      entries;
    logic [1:0]            kind;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    bit                    typed;
    logic                  hit;
    logic [FRAME_BITS-1:0] found;
  } step_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ftlb_req_if  req_ch ();
  ftlb_resp_if resp_ch ();

  fifo_tlb_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .resp    (resp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [PAGE_BITS-1:0]  tlb_page  [TLB_DEPTH];
  logic [FRAME_BITS-1:0] tlb_frame [TLB_DEPTH];
  bit                    tlb_valid [TLB_DEPTH];
  int unsigned           fill_ptr;
  int unsigned           entries_in_use;

  tlb_result_t expected_results [$];
  bit          typed_tag;
  tlb_result_t typed_res;
  int          errors;
  int          words_sent;
  int          words_checked;
  int          burst_left;
  bit          src_active;
  int          kind_count [4];
  int          hit_count;
  int          entry_writes;

  step_row_t directed_steps [29] = '{
    '{0, 0, REQ_LOOKUP, 0,                    0,                  1, 0, 0},
    '{0, 0, REQ_INSERT, PAGE_ALL,             FRAME_ALL,          1, 0, 0},
    '{0, 0, REQ_LOOKUP, PAGE_ALL,             0,                  1, 1, FRAME_ALL},
    '{0, 0, REQ_INSERT, 0,                    0,                  1, 0, 0},
    '{0, 0, REQ_LOOKUP, 0,                    FRAME_ALL,          1, 1, 0},
    '{0, 0, REQ_INSERT, PAGE_ALL,             40'hAA_AAAA_AAAA,   1, 1, 0},
    '{0, 0, REQ_LOOKUP, PAGE_ALL,             FRAME_ALL,          1, 1, 40'hAA_AAAA_AAAA},
    '{0, 0, REQ_NOP,    PAGE_ALL,             FRAME_ALL,          1, 1, 0},
    '{0, 0, REQ_LOOKUP, PAGE_ALL,             0,                  1, 1, 40'hAA_AAAA_AAAA},
    '{0, 0, REQ_INVAL,  PAGE_ALL,             FRAME_ALL,          1, 1, 0},
    '{0, 0, REQ_LOOKUP, PAGE_ALL,             0,                  1, 0, 0},
    '{0, 0, REQ_NOP,    52'h5_5555_5555_5555, 40'h55_5555_5555,   1, 0, 0},
    '{1, 2, REQ_LOOKUP, 0,                    0,                  0, 0, 0},
    '{0, 0, REQ_LOOKUP, 0,                    0,                  1, 0, 0},
    '{0, 0, REQ_INSERT, 1,                    40'h11,             1, 0, 0},
    '{0, 0, REQ_INSERT, 2,                    40'h22,             1, 0, 0},
    '{0, 0, REQ_INSERT, 3,                    40'h33,             1, 0, 0},
    '{0, 0, REQ_LOOKUP, 1,                    0,                  1, 0, 0},
    '{0, 0, REQ_LOOKUP, 3,                    0,                  1, 1, 40'h33},
    '{0, 0, REQ_LOOKUP, 2,                    0,                  1, 1, 40'h22},
    '{0, 0, REQ_INSERT, 4,                    40'h44,             1, 0, 0},
    '{0, 0, REQ_LOOKUP, 2,                    0,                  0, 0, 0},
    '{1, 0, REQ_LOOKUP, 0,                    0,                  0, 0, 0},
    '{0, 0, REQ_INSERT, 5,                    40'h55,             1, 0, 0},
    '{0, 0, REQ_LOOKUP, 5,                    0,                  1, 0, 0},
    '{1, 31, REQ_LOOKUP, 0,                   0,                  0, 0, 0},
    '{0, 0, REQ_INSERT, 5,                    FRAME_ALL,          1, 0, 0},
    '{0, 0, REQ_LOOKUP, 5,                    0,                  1, 1, FRAME_ALL},
    '{0, 0, REQ_INSERT, 52'hA_AAAA_AAAA_AAAA, 40'h55_5555_5555,   0, 0, 0}
  };

  function automatic void set_entry_count(logic [ACT_W-1:0] value);
    entries_in_use = (value > TLB_DEPTH) ? TLB_DEPTH : value;
    for (int i = 0; i < TLB_DEPTH; i++) tlb_valid[i] = 1'b0;
    fill_ptr = 0;
  endfunction

  function automatic tlb_result_t translate(tlb_req_t r);
    tlb_result_t res;
    int          match;
    int unsigned p;
    res = '0;
    match = -1;
    if (entries_in_use == 0) return res;
    for (int i = 0; i < entries_in_use && match < 0; i++) begin
      if (tlb_valid[i] && tlb_page[i] == r.page) match = i;
    end
    res.hit = (match >= 0);
    case (r.kind)
      REQ_LOOKUP: begin
        if (match >= 0) res.frame = tlb_frame[match];
      end
      REQ_INSERT: begin
        if (match >= 0) begin
          tlb_frame[match] = r.frame;
        end else begin
          p = (fill_ptr >= entries_in_use) ? 0 : fill_ptr;
          tlb_page[p]  = r.page;
          tlb_frame[p] = r.frame;
          tlb_valid[p] = 1'b1;
          fill_ptr = (p + 1 >= entries_in_use) ? 0 : p + 1;
        end
      end
      REQ_INVAL: begin
        for (int i = 0; i < entries_in_use; i++) begin
          if (tlb_valid[i] && tlb_page[i] == r.page) tlb_valid[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic logic [PAGE_BITS-1:0] random_page();
    return PAGE_BITS'({$urandom, $urandom});
  endfunction

  task automatic send_request(tlb_req_t r, bit typed, tlb_result_t res);
    int gap;
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.kind;
    req_ch.page_number <= r.page;
    req_ch.new_frame   <= r.frame;
    typed_tag          <= typed;
    typed_res          <= res;
    src_active = 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        src_active = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic go_quiet();
    if (src_active) begin
      req_ch.valid <= 1'b0;
      src_active = 1'b0;
    end
    while (words_checked != words_sent) @(posedge clk_i);
  endtask

  task automatic write_entries(logic [ACT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENTRIES_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    set_entry_count(value);
    entry_writes++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : receiver
    int hold;
    bit level;
    hold  = 0;
    level = 1'b0;
    resp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold <= 0) begin
        case ($urandom_range(0, 5))
          0: begin
            level = 1'b0;
            hold  = $urandom_range(1, 40);
          end
          1: begin
            level = 1'b1;
            hold  = $urandom_range(50, 300);
          end
          default: begin
            level = $urandom_range(0, 1);
            hold  = $urandom_range(1, 12);
          end
        endcase
      end
      hold--;
      resp_ch.ready <= level;
    end
  end

  always @(posedge clk_i) begin : monitor
    tlb_result_t want;
    tlb_result_t got;
    if (rst_ni) begin
      if (resp_ch.valid && resp_ch.ready) begin
        words_checked++;
        if (expected_results.size() == 0) begin
          $error("unexpected result word: hit %0b found_frame %h",
                 resp_ch.hit, resp_ch.found_frame);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (resp_ch.hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, resp_ch.hit);
            errors++;
          end
          if (resp_ch.found_frame !== want.frame) begin
            $error("found_frame: expected %h, actual %h", want.frame, resp_ch.found_frame);
            errors++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        got = translate(tlb_req_t'{req_ch.req_type, req_ch.page_number, req_ch.new_frame});
        expected_results.push_back(typed_tag ? typed_res : got);
        kind_count[req_ch.req_type]++;
        if (got.hit) hit_count++;
      end
    end
  end

  initial begin
    logic [PAGE_BITS-1:0] page_pool [POOL_MAX];
    int                   phase_entries [8];
    int                   pool_n;
    int                   sel;
    tlb_req_t             r;

    rst_ni             <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_LOOKUP;
    req_ch.page_number <= '0;
    req_ch.new_frame   <= '0;
    typed_tag          <= 1'b0;
    typed_res          <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    errors        = 0;
    words_sent    = 0;
    words_checked = 0;
    burst_left    = 1;
    src_active    = 1'b0;
    hit_count     = 0;
    entry_writes  = 0;
    for (int k = 0; k < 4; k++) kind_count[k] = 0;
    set_entry_count(ACT_W'(ACT_RESET));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[s]) begin
      if (directed_steps[s].cfg) begin
        go_quiet();
        write_entries(directed_steps[s].entries);
      end else begin
        send_request(tlb_req_t'{directed_steps[s].kind, directed_steps[s].page,
                                directed_steps[s].frame},
                     directed_steps[s].typed,
                     tlb_result_t'{directed_steps[s].hit, directed_steps[s].found});
      end
    end

    phase_entries = '{16, 1, 0, 7, 23, 0, 2, 16};
    phase_entries[5] = $urandom_range(3, 31);
    foreach (phase_entries[ph]) begin
      go_quiet();
      write_entries(ACT_W'(phase_entries[ph]));
      pool_n = entries_in_use + 3;
      if (pool_n > POOL_MAX) pool_n = POOL_MAX;
      for (int k = 0; k < POOL_MAX; k++) page_pool[k] = random_page();
      repeat (125) begin
        sel = $urandom_range(0, 99);
        r.kind  = (sel < 45) ? REQ_LOOKUP : (sel < 78) ? REQ_INSERT :
                  (sel < 95) ? REQ_INVAL : REQ_NOP;
        r.page  = ($urandom_range(0, 7) == 0) ? random_page()
                                              : page_pool[$urandom_range(0, pool_n - 1)];
        r.frame = FRAME_BITS'({$urandom, $urandom});
        send_request(r, 1'b0, '0);
      end
    end

    go_quiet();
    repeat (4 * TLB_DEPTH) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      errors++;
    end
    $display("testbench: %0d requests (%0d lookup, %0d insert, %0d invalidate, %0d no-op), %0d hits",
             words_sent, kind_count[REQ_LOOKUP], kind_count[REQ_INSERT],
             kind_count[REQ_INVAL], kind_count[REQ_NOP], hit_count);
    $display("testbench: %0d entry-count writes, disabled and saturated settings among them",
             entry_writes);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ftlb_pkg.sv
sv/ftlb_req_if.sv
sv/ftlb_resp_if.sv
sv/ftlb_cell.sv
sv/fifo_tlb_top.sv
tb/sv/testbench.sv
